// File: rtl/ntad_pkg.sv
package ntad_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DIGIT_W         = 4;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_X    = 8'h78;
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

   // Operation applied to every cell of the digit chain together.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DEC,    // double-dabble step: add 3 if >= 5, then shift one bit
      CELL_HEX,    // plain one-bit shift, nibbles are the hex digits
      CELL_MOVE    // move whole digits one cell toward the top
   } cell_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_PRE0,
      S_PREX,
      S_DIGIT
   } state_type;

   function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [7:0] c;
      if (d < DEC_BASE) begin
         c = CHAR_ZERO + {4'd0, d};
      end else begin
         c = CHAR_A + {4'd0, d - DEC_BASE};
      end
      return c;
   endfunction

endpackage

// File: rtl/number_to_ascii_digits.sv
// Renders an unsigned number as ASCII text, most significant character first.
// Input channel (req_): tdata carries the value, tuser the kind (0 decimal,
// 1 hex with a "0x" prefix). A transfer is taken only while the block is idle.
// Result channel (rsp_): one transfer per character in tdata, tlast on the
// final one. Neither kind has leading zeros; zero renders as "0" or "0x0".
// Per item: the input transfer, then conversion in the cell chain (one bit per cycle,
// double-dabble for decimal, plain shift for hex), then the hex prefix, then the digits
// moved out of the top cell (leading zeros are dropped one per cycle). The first
// character is the hex prefix or, for decimal, the top digit that is not a leading zero.
// The result register lets the chain keep dropping leading zeros while a
// character waits; a stall on rsp_tready holds the chain at the next
// character, nothing is lost. The next item is taken as soon as the final
// character has been loaded into the result register.
// Reset (synchronous, active high) returns the control to idle and empties
// the result register; a run in progress is abandoned.
module number_to_ascii_digits
   import ntad_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   req_tdata,   // [VALUE_WIDTH-1:0] value
   input  logic                               req_tuser,   // [0] kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [7:0] out_char
   output logic                               rsp_tlast
);

   // Decimal digits needed for VALUE_WIDTH bits, hex digits, and the chain length.
   localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int HEX_DIGITS = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
   localparam int NCELL      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_CNT_W  = $clog2(NCELL + 1);

   localparam logic [BIT_CNT_W-1:0] BIT_CNT_INIT = BIT_CNT_W'(VALUE_WIDTH);
   localparam logic [BIT_CNT_W-1:0] BIT_CNT_ONE  = BIT_CNT_W'(1);
   localparam logic [DIG_CNT_W-1:0] DIG_CNT_INIT = DIG_CNT_W'(NCELL);
   localparam logic [DIG_CNT_W-1:0] DIG_CNT_ONE  = DIG_CNT_W'(1);

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   val_ff, val_in;
   logic                     kind_ff, kind_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]     dig_cnt_ff, dig_cnt_in;
   logic                     started_ff, started_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_op_type              cell_op;
   logic [DIGIT_W-1:0]       digit [NCELL];
   logic                     carry [NCELL];
   logic [DIGIT_W-1:0]       top_digit;
   logic                     out_free;

   // Digit chain: cell 0 is least significant, bits enter at the bottom,
   // digits leave at the top.
   assign carry[0] = val_ff[VALUE_WIDTH-1];

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      if (i == NCELL - 1) begin : g_top
         ntad_cell u_cell (
            .clock     (clock),
            .op        (cell_op),
            .bit_in    (carry[i]),
            .nib_in    (digit[i-1]),
            .digit     (digit[i]),
            .carry_out ()
         );
      end else if (i == 0) begin : g_bottom
         ntad_cell u_cell (
            .clock     (clock),
            .op        (cell_op),
            .bit_in    (carry[i]),
            .nib_in    ('0),
            .digit     (digit[i]),
            .carry_out (carry[i+1])
         );
      end else begin : g_mid
         ntad_cell u_cell (
            .clock     (clock),
            .op        (cell_op),
            .bit_in    (carry[i]),
            .nib_in    (digit[i-1]),
            .digit     (digit[i]),
            .carry_out (carry[i+1])
         );
      end
   end

   assign top_digit = digit[NCELL-1];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      kind_in      = kind_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      started_in   = started_ff;
      cell_op      = CELL_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               val_in     = req_tdata[VALUE_WIDTH-1:0];
               kind_in    = req_tuser;
               bit_cnt_in = BIT_CNT_INIT;
               dig_cnt_in = DIG_CNT_INIT;
               started_in = 1'b0;
               cell_op    = CELL_CLEAR;
               state_in   = S_CONV;
            end
         end
         S_CONV: begin
            cell_op    = kind_ff ? CELL_HEX : CELL_DEC;
            val_in     = {val_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_ONE;
            if (bit_cnt_ff == BIT_CNT_ONE) begin
               state_in = kind_ff ? S_PRE0 : S_DIGIT;
            end
         end
         S_PRE0: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO;
               rsp_last_in  = 1'b0;
               state_in     = S_PREX;
            end
         end
         S_PREX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_X;
               rsp_last_in  = 1'b0;
               state_in     = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (!started_ff && top_digit == '0 && dig_cnt_ff != DIG_CNT_ONE) begin
               // leading zero: drop it
               cell_op    = CELL_MOVE;
               dig_cnt_in = dig_cnt_ff - DIG_CNT_ONE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(top_digit);
               rsp_last_in  = (dig_cnt_ff == DIG_CNT_ONE);
               started_in   = 1'b1;
               cell_op      = CELL_MOVE;
               dig_cnt_in   = dig_cnt_ff - DIG_CNT_ONE;
               if (dig_cnt_ff == DIG_CNT_ONE) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      kind_ff     <= kind_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      started_ff  <= started_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/ntad_cell.sv
module ntad_cell
   import ntad_pkg::*;
(
   input  logic               clock,
   input  cell_op_type        op,
   input  logic               bit_in,
   input  logic [DIGIT_W-1:0] nib_in,
   output logic [DIGIT_W-1:0] digit,
   output logic               carry_out
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   // BCD correction before the shift
   assign adj = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;

   always_comb begin
      digit_in  = digit_ff;
      carry_out = digit_ff[DIGIT_W-1];
      case (op)
         CELL_HOLD: begin
            digit_in = digit_ff;
         end
         CELL_CLEAR: begin
            digit_in = '0;
         end
         CELL_DEC: begin
            digit_in  = {adj[DIGIT_W-2:0], bit_in};
            carry_out = adj[DIGIT_W-1];
         end
         CELL_HEX: begin
            digit_in = {digit_ff[DIGIT_W-2:0], bit_in};
         end
         CELL_MOVE: begin
            digit_in = nib_in;
         end
         default: begin
            digit_in = digit_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule
